// ===== design/lbd_pkg.sv =====
// Package: shared types and constants for the letterbox border detector.
`default_nettype none
package lbd_pkg;
    localparam int MaxWidthDef  = 2048;
    localparam int MaxHeightDef = 2048;
    localparam int AccW         = 40;
    localparam int PixW         = 8;
    localparam int SizeW        = 12;
    localparam int PosW         = 11;
    localparam int CountW       = 8;
    localparam int ThrW         = 16;
    localparam int DiffW        = 16;
    localparam int CfgIdxW      = 2;

    typedef enum logic [1:0] {
        K_PIXEL  = 2'd0,
        K_CHECK  = 2'd1,
        K_FINISH = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_COUNT  = 2'd2,
        REG_THRESH = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_CHK_RD0,
        ST_CHK_RD1,
        ST_CHK_EVAL,
        ST_SCAN_L,
        ST_SCAN_R,
        ST_SCAN_T,
        ST_SCAN_B,
        ST_REPORT,
        ST_WIPE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [SizeW-1:0]  frame_width;
        logic [SizeW-1:0]  frame_height;
        logic [CountW-1:0] frame_count;
        logic [ThrW-1:0]   cut_threshold;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] column;
        logic [10:0] line;
        logic [7:0]  red_before;
        logic [7:0]  green_before;
        logic [7:0]  blue_before;
        logic [7:0]  red_after;
        logic [7:0]  green_after;
        logic [7:0]  blue_after;
    } t_in_word;

    typedef struct packed {
        logic        is_final;
        logic        skip_border;
        logic        crop_valid;
        logic [11:0] crop_left;
        logic [11:0] crop_right;
        logic [11:0] crop_top;
        logic [11:0] crop_bottom;
    } t_out_word;
endpackage
`default_nettype wire

// ===== design/lbd_if.sv =====
// Interfaces: input, result and configuration valid/ready channels.
`default_nettype none
interface lbd_in_if;
    logic               valid;
    logic               ready;
    lbd_pkg::t_in_word  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbd_out_if;
    logic               valid;
    logic               ready;
    lbd_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lbd_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lbd_pkg::CfgIdxW-1:0]   index;
    logic [31:0]                   wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ===== design/lbd_diff.sv =====
// RMS color difference: iterative sqrt(S*65536/3), one result bit per cycle.
`default_nettype none
module lbd_diff (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [7:0]                    i_rb, i_gb, i_bb, i_ra, i_ga, i_ba,
    output logic                               o_done,
    output logic [lbd_pkg::DiffW-1:0]          o_value
);
    // S <= 3*65025, S*65536/3 < 2^32: 16 result bits
    localparam int QW = 32;

    logic [17:0]        r_s;
    logic [QW-1:0]      r_q;
    logic [QW-1:0]      r_rem;
    logic [15:0]        r_root;
    logic [4:0]         r_step;
    logic               r_busy, r_load, r_div;
    logic [QW+1:0]      n_trial;
    logic [QW+1:0]      n_rem2;
    logic [35:0]        n_prod;
    logic [15:0]        n_quo;
    logic [1:0]         n_mod;
    logic [QW-1:0]      n_q;

    function automatic logic [15:0] sq8(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a > b) ? a - b : b - a;
        return 16'(d) * 16'(d);
    endfunction

    // S/3 by reciprocal multiply (exact for S < 2^19), remainder picks the fraction
    always_comb begin
        n_prod = 36'(r_s) * 36'd174763;
        n_quo  = n_prod[34:19];
        n_mod  = 2'(r_s - 18'(n_quo) * 18'd3);
        case (n_mod)
            2'd1:    n_q = {n_quo, 16'd0} + 32'd21845;
            2'd2:    n_q = {n_quo, 16'd0} + 32'd43690;
            default: n_q = {n_quo, 16'd0};
        endcase
    end

    // one root bit per cycle: rem = rem*4 + next two bits of q
    always_comb begin
        n_rem2  = {r_rem, r_q[QW-1:QW-2]};
        n_trial = {16'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_load <= 1'b0;
            r_div  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_load <= i_start;
            r_div  <= r_load;
            if (i_start)
                r_s <= 18'(sq8(i_ra, i_rb)) + 18'(sq8(i_ga, i_gb)) + 18'(sq8(i_ba, i_bb));
            if (r_load)
                r_q <= n_q;
            if (r_div) begin
                r_busy <= 1'b1;
                r_step <= 5'd0;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_q <= r_q << 2;
                if (n_rem2 >= n_trial) begin
                    r_rem  <= QW'(n_rem2 - n_trial);
                    r_root <= {r_root[14:0], 1'b1};
                end else begin
                    r_rem  <= QW'(n_rem2);
                    r_root <= {r_root[14:0], 1'b0};
                end
                r_step <= r_step + 5'd1;
                if (r_step == 5'd15) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_value = r_root;
endmodule
`default_nettype wire

// ===== design/lbd_store.sv =====
// Activity store: one synchronous RAM of saturating sums with a registered read port.
`default_nettype none
module lbd_store #(
    parameter int Depth = lbd_pkg::MaxWidthDef
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(Depth)-1:0]    i_waddr,
    input  wire logic [lbd_pkg::AccW-1:0]    i_wdata,
    input  wire logic [$clog2(Depth)-1:0]    i_raddr,
    output logic      [lbd_pkg::AccW-1:0]    o_rdata
);
    logic [lbd_pkg::AccW-1:0] r_mem [Depth];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== design/letterbox_border_detector.sv =====
// Top level: control sequencer, row/column activity stores and config registers.
// Pixel word: the root unit runs, then a RAM read-modify-write, before the next accept.
// End-of-pair word: two reads and an evaluation state give the result; idle once it is taken.
// Finish word: unless skipped, the scans make at most W+H+2 RAM reads, then a wipe pass
// over max(MAX_WIDTH,MAX_HEIGHT) addresses runs before the result. After reset a clearing
// pass over max(MAX_WIDTH,MAX_HEIGHT) addresses runs before the first word is taken.
`default_nettype none
module letterbox_border_detector #(
    parameter int MAX_WIDTH  = lbd_pkg::MaxWidthDef,
    parameter int MAX_HEIGHT = lbd_pkg::MaxHeightDef
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    lbd_in_if.sink     in_ch,
    lbd_out_if.source  out_ch,
    lbd_cfg_if.sink    cfg_ch
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int MaxD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int CW = $clog2(MaxD + 1);
    localparam int AW = lbd_pkg::AccW;
    localparam logic [AW-1:0] AccMax = '1;

    lbd_pkg::t_cfg     r_cfg;
    lbd_pkg::t_state   r_state, n_state;
    lbd_pkg::t_in_word r_in;
    lbd_pkg::t_out_word r_out;
    logic              r_skipped;
    logic              r_out_valid;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_x1, r_x2, r_y1, r_y2;
    logic [AW-1:0]     r_col0, r_row0;
    logic [AW-1:0]     r_row_thr, r_col_thr;
    logic [CW-1:0]     r_w, r_h;
    logic              r_rd_pend;

    // config register writes
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width   <= 12'd640;
            r_cfg.frame_height  <= 12'd480;
            r_cfg.frame_count   <= 8'd10;
            r_cfg.cut_threshold <= 16'd2560;
        end else if (cfg_ch.valid) begin
            case (lbd_pkg::t_reg'(cfg_ch.index))
                lbd_pkg::REG_WIDTH:  r_cfg.frame_width   <= cfg_ch.wdata[11:0];
                lbd_pkg::REG_HEIGHT: r_cfg.frame_height  <= cfg_ch.wdata[11:0];
                lbd_pkg::REG_COUNT:  r_cfg.frame_count   <= cfg_ch.wdata[7:0];
                lbd_pkg::REG_THRESH: r_cfg.cut_threshold <= cfg_ch.wdata[15:0];
                default: ;
            endcase
        end
    end

    // clamped sizes and thresholds, registered (the user keeps config stable while idle; not enforced here)
    logic [23:0] r_tc;
    always_ff @(posedge i_clk) begin
        if (r_cfg.frame_width == 12'd0)          r_w <= CW'(1);
        else if (32'(r_cfg.frame_width) > MAX_WIDTH) r_w <= CW'(MAX_WIDTH);
        else                                     r_w <= CW'(r_cfg.frame_width);
        if (r_cfg.frame_height == 12'd0)         r_h <= CW'(1);
        else if (32'(r_cfg.frame_height) > MAX_HEIGHT) r_h <= CW'(MAX_HEIGHT);
        else                                     r_h <= CW'(r_cfg.frame_height);
        r_tc      <= 24'(r_cfg.cut_threshold) * 24'(r_cfg.frame_count);
        r_row_thr <= AW'(r_tc) * AW'(r_w);
        r_col_thr <= AW'(r_tc) * AW'(r_h);
    end

    // root unit
    logic              diff_done;
    logic [15:0]       diff_val;
    logic              diff_start;
    assign diff_start = in_ch.valid && in_ch.ready
        && lbd_pkg::t_kind'(in_ch.data.kind) == lbd_pkg::K_PIXEL;
    lbd_diff u_diff (
        .i_clk, .i_rst_n, .i_start(diff_start),
        .i_rb(in_ch.data.red_before), .i_gb(in_ch.data.green_before),
        .i_bb(in_ch.data.blue_before), .i_ra(in_ch.data.red_after),
        .i_ga(in_ch.data.green_after), .i_ba(in_ch.data.blue_after),
        .o_done(diff_done), .o_value(diff_val)
    );
    logic [15:0] r_diff;

    // stores
    logic          col_we, row_we;
    logic [XW-1:0] col_waddr, col_raddr;
    logic [YW-1:0] row_waddr, row_raddr;
    logic [AW-1:0] col_wdata, row_wdata, col_rdata, row_rdata;
    lbd_store #(.Depth(MAX_WIDTH)) u_col (
        .i_clk, .i_we(col_we), .i_waddr(col_waddr), .i_wdata(col_wdata),
        .i_raddr(col_raddr), .o_rdata(col_rdata));
    lbd_store #(.Depth(MAX_HEIGHT)) u_row (
        .i_clk, .i_we(row_we), .i_waddr(row_waddr), .i_wdata(row_wdata),
        .i_raddr(row_raddr), .o_rdata(row_rdata));

    logic in_pic;
    assign in_pic = !r_skipped && ((CW+12)'(r_in.column) < (CW+12)'(r_w))
                    && ((CW+12)'(r_in.line) < (CW+12)'(r_h));

    // scan positions
    logic [CW-1:0] scan_idx;
    always_comb begin
        case (r_state)
            lbd_pkg::ST_SCAN_L: scan_idx = r_x1;
            lbd_pkg::ST_SCAN_R: scan_idx = r_w - CW'(1) - r_x2;
            lbd_pkg::ST_SCAN_T: scan_idx = r_y1;
            lbd_pkg::ST_SCAN_B: scan_idx = r_h - CW'(1) - r_y2;
            default:            scan_idx = '0;
        endcase
    end
    logic scan_more, col_low, row_low;
    assign col_low = col_rdata < r_col_thr;
    assign row_low = row_rdata < r_row_thr;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbd_pkg::ST_CLEAR, lbd_pkg::ST_WIPE:
                if (r_cnt == CW'(MaxD - 1))
                    n_state = (r_state == lbd_pkg::ST_WIPE) ? lbd_pkg::ST_OUT
                                                             : lbd_pkg::ST_IDLE;
            lbd_pkg::ST_IDLE:
                if (in_ch.valid) begin
                    case (lbd_pkg::t_kind'(in_ch.data.kind))
                        lbd_pkg::K_PIXEL:  n_state = lbd_pkg::ST_PIX_RD;
                        lbd_pkg::K_CHECK:  n_state = lbd_pkg::ST_CHK_RD0;
                        lbd_pkg::K_FINISH: n_state = r_skipped ? lbd_pkg::ST_REPORT
                                                               : lbd_pkg::ST_SCAN_L;
                        default:           n_state = lbd_pkg::ST_IDLE;
                    endcase
                end
            lbd_pkg::ST_PIX_RD:  if (diff_done) n_state = lbd_pkg::ST_PIX_WR;
            lbd_pkg::ST_PIX_WR:  n_state = lbd_pkg::ST_IDLE;
            lbd_pkg::ST_CHK_RD0: n_state = lbd_pkg::ST_CHK_RD1;
            lbd_pkg::ST_CHK_RD1: n_state = lbd_pkg::ST_CHK_EVAL;
            lbd_pkg::ST_CHK_EVAL: n_state = lbd_pkg::ST_OUT;
            lbd_pkg::ST_SCAN_L:
                if (r_rd_pend && !(col_low && r_x1 < r_w)) n_state = lbd_pkg::ST_SCAN_R;
                else if (!r_rd_pend && r_x1 >= r_w)        n_state = lbd_pkg::ST_SCAN_R;
            lbd_pkg::ST_SCAN_R:
                if (r_rd_pend && !col_low)                 n_state = lbd_pkg::ST_SCAN_T;
                else if (!r_rd_pend && r_x1 + r_x2 >= r_w) n_state = lbd_pkg::ST_SCAN_T;
            lbd_pkg::ST_SCAN_T:
                if (r_rd_pend && !row_low)                 n_state = lbd_pkg::ST_SCAN_B;
                else if (!r_rd_pend && r_y1 >= r_h)        n_state = lbd_pkg::ST_SCAN_B;
            lbd_pkg::ST_SCAN_B:
                if (r_rd_pend && !row_low)                 n_state = lbd_pkg::ST_REPORT;
                else if (!r_rd_pend && r_y1 + r_y2 >= r_h) n_state = lbd_pkg::ST_REPORT;
            lbd_pkg::ST_REPORT:  n_state = lbd_pkg::ST_WIPE;
            lbd_pkg::ST_OUT:     if (!r_out_valid) n_state = lbd_pkg::ST_IDLE;
            default:             n_state = lbd_pkg::ST_IDLE;
        endcase
    end
    assign scan_more = 1'b1;

    // outputs to stores and ready
    always_comb begin
        in_ch.ready = (r_state == lbd_pkg::ST_IDLE);
        col_we = 1'b0; row_we = 1'b0;
        col_waddr = XW'(r_in.column);
        row_waddr = YW'(r_in.line);
        col_wdata = '0; row_wdata = '0;
        col_raddr = XW'(r_in.column);
        row_raddr = YW'(r_in.line);
        case (r_state)
            lbd_pkg::ST_CLEAR, lbd_pkg::ST_WIPE: begin
                col_we = (r_cnt < CW'(MAX_WIDTH)) && scan_more;
                row_we = r_cnt < CW'(MAX_HEIGHT);
                col_waddr = r_cnt[XW-1:0];
                row_waddr = r_cnt[YW-1:0];
            end
            lbd_pkg::ST_PIX_WR: begin
                col_we = in_pic; row_we = in_pic;
                col_wdata = (col_rdata > AccMax - AW'(r_diff)) ? AccMax
                                                                : col_rdata + AW'(r_diff);
                row_wdata = (row_rdata > AccMax - AW'(r_diff)) ? AccMax
                                                                : row_rdata + AW'(r_diff);
            end
            lbd_pkg::ST_CHK_RD0: begin
                col_raddr = '0; row_raddr = '0;
            end
            lbd_pkg::ST_CHK_RD1: begin
                col_raddr = XW'(r_w - CW'(1));
                row_raddr = YW'(r_h - CW'(1));
            end
            lbd_pkg::ST_SCAN_L, lbd_pkg::ST_SCAN_R: col_raddr = XW'(scan_idx);
            lbd_pkg::ST_SCAN_T, lbd_pkg::ST_SCAN_B: row_raddr = YW'(scan_idx);
            default: ;
        endcase
    end

    // datapath registers
    logic chk_all;
    assign chk_all = (r_row0 > r_row_thr) && (row_rdata > r_row_thr)
                   && (r_col0 > r_col_thr) && (col_rdata > r_col_thr);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lbd_pkg::ST_CLEAR;
            r_cnt       <= '0;
            r_skipped   <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_state <= n_state;
            // result valid: set when a report is ready, cleared when taken
            if (r_state == lbd_pkg::ST_CHK_EVAL
                || (r_state == lbd_pkg::ST_WIPE && r_cnt == CW'(MaxD - 1)))
                r_out_valid <= 1'b1;
            else if (out_ch.ready)
                r_out_valid <= 1'b0;
            if (r_state == lbd_pkg::ST_CLEAR || r_state == lbd_pkg::ST_WIPE)
                r_cnt <= r_cnt + CW'(1);
            else
                r_cnt <= '0;
            if (in_ch.valid && in_ch.ready) begin
                r_in <= in_ch.data;
                r_x1 <= '0; r_x2 <= '0; r_y1 <= '0; r_y2 <= '0;
            end
            if (diff_done) r_diff <= diff_val;
            if (r_state == lbd_pkg::ST_CHK_RD1) begin
                r_row0 <= row_rdata;
                r_col0 <= col_rdata;
            end
            if (r_state == lbd_pkg::ST_CHK_EVAL) begin
                if (!r_skipped && chk_all) r_skipped <= 1'b1;
                r_out <= '{skip_border: (r_skipped || chk_all), default: '0};
            end
            // scans: issue read when bounds pass, test the data in the cycle after
            case (r_state)
                lbd_pkg::ST_SCAN_L:
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (col_low) r_x1 <= r_x1 + CW'(1);
                    end else r_rd_pend <= (r_x1 < r_w);
                lbd_pkg::ST_SCAN_R:
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (col_low) r_x2 <= r_x2 + CW'(1);
                    end else r_rd_pend <= (r_x1 + r_x2 < r_w);
                lbd_pkg::ST_SCAN_T:
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (row_low) r_y1 <= r_y1 + CW'(1);
                    end else r_rd_pend <= (r_y1 < r_h);
                lbd_pkg::ST_SCAN_B:
                    if (r_rd_pend) begin
                        r_rd_pend <= 1'b0;
                        if (row_low) r_y2 <= r_y2 + CW'(1);
                    end else r_rd_pend <= (r_y1 + r_y2 < r_h);
                default: r_rd_pend <= 1'b0;
            endcase
            if (r_state == lbd_pkg::ST_REPORT) begin
                if (!r_skipped && (r_x1 + r_x2 < r_w) && (r_y1 + r_y2 < r_h))
                    r_out <= '{is_final: 1'b1, skip_border: 1'b0, crop_valid: 1'b1,
                               crop_left: 12'(r_x1), crop_right: 12'(r_x2),
                               crop_top: 12'(r_y1), crop_bottom: 12'(r_y2)};
                else
                    r_out <= '{is_final: 1'b1, skip_border: r_skipped, default: '0};
                r_skipped <= 1'b0;
            end
        end
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.data  = r_out;
endmodule
`default_nettype wire

// ===== design/lbd_checker.sv =====
// Port-level checker for the letterbox border detector, bound to the top level.
`default_nettype none
module lbd_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire lbd_pkg::t_out_word out_data
);
    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> $stable(out_data)) else $error("result changed");
    // no input taken while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    // crop left and top are zero unless crop valid
    a_crop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_data.crop_valid |-> out_data.crop_left == 12'd0
        && out_data.crop_top == 12'd0) else $error("crop without valid");
    // a valid crop is a final report without skip
    a_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.crop_valid |-> out_data.is_final && !out_data.skip_border)
        else $error("bad crop report");
endmodule

bind letterbox_border_detector lbd_checker u_lbd_checker (
    .i_clk, .i_rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
);
`default_nettype wire
